@@ rtl/core/c2es_pkg.sv @@
`default_nettype none

package c2es_pkg;

  localparam int unsigned YearW       = 12;
  localparam int unsigned YicW        = 7;
  localparam int unsigned MonthW      = 4;
  localparam int unsigned DayW        = 5;
  localparam int unsigned WeekdayW    = 3;
  localparam int unsigned HoursW      = 5;
  localparam int unsigned MinutesW    = 6;
  localparam int unsigned SecondsW    = 6;
  localparam int unsigned EpochW      = 32;

  localparam logic [YearW-1:0] BaseCentury    = 12'd2000;
  localparam logic [YearW-1:0] MinYearReset   = 12'd2010;
  localparam logic [YicW-1:0]  FirstLeapYic   = 7'd4;
  localparam logic [16:0]      SecsPerDay     = 17'd86400;
  localparam logic [11:0]      SecsPerHour    = 12'd3600;
  localparam logic [5:0]       SecsPerMinute  = 6'd60;
  localparam logic [24:0]      SecsPerYear    = 25'd31536000;

  // one calendar reading
  typedef struct packed {
    logic [YicW-1:0]     year_in_century;
    logic [MonthW-1:0]   month;
    logic [DayW-1:0]     day_of_month;
    logic [WeekdayW-1:0] weekday;
    logic [HoursW-1:0]   hours;
    logic [MinutesW-1:0] minutes;
    logic [SecondsW-1:0] seconds;
  } in_t;

  // one result
  typedef struct packed {
    logic [EpochW-1:0] epoch_seconds;
    logic              time_suspect;
  } out_t;

  // reading after date cleanup, held between front and calc stages
  typedef struct packed {
    logic [YicW-1:0]     yic;
    logic [MonthW-1:0]   month;
    logic [DayW-1:0]     day;
    logic [HoursW-1:0]   hours;
    logic [MinutesW-1:0] minutes;
    logic [SecondsW-1:0] seconds;
    logic                suspect;
  } stage_t;

  // days before the first of the month in a plain year, months above twelve as twelve
  function automatic logic [8:0] days_before_month(input logic [MonthW-1:0] m);
    logic [8:0] d;
    case (m) inside
      4'd2:    d = 9'd31;
      4'd3:    d = 9'd59;
      4'd4:    d = 9'd90;
      4'd5:    d = 9'd120;
      4'd6:    d = 9'd151;
      4'd7:    d = 9'd181;
      4'd8:    d = 9'd212;
      4'd9:    d = 9'd243;
      4'd10:   d = 9'd273;
      4'd11:   d = 9'd304;
      [4'd12:4'd15]: d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/c2es_front.sv @@
`default_nettype none

module c2es_front (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output      logic                           in_ready_o,
  input  wire c2es_pkg::in_t                  in_data_i,
  input  wire logic [c2es_pkg::YearW-1:0]     min_year_i,
  input  wire logic                           take_i,
  output      logic                           s1_valid_o,
  output      c2es_pkg::stage_t               s1_data_o
);

  logic                              s1_valid_q, s1_valid_d;
  c2es_pkg::stage_t                  s1_data_q, s1_data_d;
  logic [c2es_pkg::SecondsW-1:0]     prev_q, prev_d;
  logic                              suspect_q, suspect_d;
  logic                              accept;
  logic                              changed;
  logic                              bad_date;
  logic [c2es_pkg::YicW-1:0]         yic_s;
  logic [c2es_pkg::YearW-1:0]        year;

  // stage register frees up when empty or passing its item on
  assign in_ready_o = !s1_valid_q || take_i;
  assign accept     = in_valid_i && in_ready_o;
  assign changed    = in_data_i.seconds != prev_q;

  // invalid date falls back to 2001-01-01
  assign bad_date = (in_data_i.year_in_century == '0) || (in_data_i.month == '0) ||
                    (in_data_i.day_of_month == '0) || (in_data_i.weekday == '0);
  assign yic_s    = bad_date ? c2es_pkg::YicW'(1) : in_data_i.year_in_century;
  assign year     = c2es_pkg::BaseCentury + c2es_pkg::YearW'(yic_s);

  // change detect, sticky suspect and stage load
  always_comb begin
    prev_d     = prev_q;
    suspect_d  = suspect_q;
    s1_valid_d = s1_valid_q && !take_i;
    s1_data_d  = s1_data_q;
    if (accept && changed) begin
      prev_d     = in_data_i.seconds;
      suspect_d  = suspect_q || (year < min_year_i);
      s1_valid_d = 1'b1;
      s1_data_d.yic     = yic_s;
      s1_data_d.month   = bad_date ? c2es_pkg::MonthW'(1) : in_data_i.month;
      s1_data_d.day     = bad_date ? c2es_pkg::DayW'(1) : in_data_i.day_of_month;
      s1_data_d.hours   = in_data_i.hours;
      s1_data_d.minutes = in_data_i.minutes;
      s1_data_d.seconds = in_data_i.seconds;
      s1_data_d.suspect = suspect_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      prev_q     <= '0;
      suspect_q  <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      prev_q     <= prev_d;
      suspect_q  <= suspect_d;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk_i) begin
    s1_data_q <= s1_data_d;
  end

  assign s1_valid_o = s1_valid_q;
  assign s1_data_o  = s1_data_q;

  // suspect flag is sticky
  a_suspect_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$fell(suspect_q))
    else $error("suspect flag cleared");

  // repeated seconds value yields nothing
  a_repeat_dropped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !changed) |=> !s1_valid_q)
    else $error("repeated reading entered stage");

  // new seconds value is loaded and remembered
  a_change_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && changed) |=> (s1_valid_q && prev_q == s1_data_q.seconds))
    else $error("changed reading not loaded");

endmodule

`default_nettype wire

@@ rtl/core/c2es_calc.sv @@
`default_nettype none

module c2es_calc (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             s1_valid_i,
  input  wire c2es_pkg::stage_t s1_data_i,
  output      logic             take_o,
  output      logic             out_valid_o,
  input  wire logic             out_ready_i,
  output      c2es_pkg::out_t   out_data_o
);

  logic                        out_valid_q;
  c2es_pkg::out_t              out_data_q, out_data_d;
  logic                        leap;
  logic [6:0]                  yic_m5;
  logic [4:0]                  leap_days;
  logic [6:0]                  dyears;
  logic [8:0]                  doy;
  logic [9:0]                  days;
  logic [16:0]                 tod;
  logic [26:0]                 day_secs;
  logic [31:0]                 year_secs;

  // result register takes a new item when empty or being drained
  assign take_o = s1_valid_i && (!out_valid_q || out_ready_i);

  // leap handling: divisible by four from 2004 on
  assign leap      = (s1_data_i.yic >= c2es_pkg::FirstLeapYic) && (s1_data_i.yic[1:0] == 2'b00);
  assign yic_m5    = s1_data_i.yic - 7'd5;
  assign leap_days = (s1_data_i.yic > c2es_pkg::FirstLeapYic) ?
                     (5'(yic_m5 >> 2) + 5'd1) : 5'd0;
  assign dyears    = s1_data_i.yic - 7'd1;

  // day of year plus leap days since 2004
  assign doy  = c2es_pkg::days_before_month(s1_data_i.month)
              + 9'((leap && (s1_data_i.month >= 4'd3)) ? 1 : 0)
              + 9'(s1_data_i.day - 5'd1);
  assign days = 10'(doy) + 10'(leap_days);

  // time of day and weighted sums
  assign tod = 17'(s1_data_i.hours) * 17'(c2es_pkg::SecsPerHour)
             + 17'(s1_data_i.minutes) * 17'(c2es_pkg::SecsPerMinute)
             + 17'(s1_data_i.seconds);
  assign day_secs  = 27'(days) * 27'(c2es_pkg::SecsPerDay);
  assign year_secs = 32'(dyears) * 32'(c2es_pkg::SecsPerYear);

  always_comb begin
    out_data_d               = out_data_q;
    if (take_o) begin
      out_data_d.epoch_seconds = year_secs + 32'(day_secs) + 32'(tod);
      out_data_d.time_suspect  = s1_data_i.suspect;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (take_o) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

`default_nettype wire

@@ rtl/core/calendar_to_epoch_seconds.sv @@
// calendar reading to seconds since 2001-01-01 00:00:00
//
// in channel: in_valid_i / in_ready_o carry one reading (in_data_i) per transfer.
// out channel: out_valid_o / out_ready_i carry one result (out_data_o) per transfer.
// cfg channel: cfg_valid_i / cfg_ready_o write minimum_year; always ready,
// to be written only while the block is idle.
// a reading whose seconds field equals the previous reading's gives no result.
// a reading goes through the input stage register, then the result register.
// throughput: one reading per cycle while out_ready_i is high; the result register
// and the input stage form a two-entry pipeline.
// when out_ready_i is low the result holds, the input stage fills, and then
// in_ready_o drops until the result is taken.
// reset: pipeline empty, previous seconds 0, suspect flag clear,
// minimum_year MinYearInit, 2010 by default.

`default_nettype none

module calendar_to_epoch_seconds #(
  parameter logic [c2es_pkg::YearW-1:0] MinYearInit = c2es_pkg::MinYearReset
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output      logic                       in_ready_o,
  input  wire c2es_pkg::in_t              in_data_i,
  output      logic                       out_valid_o,
  input  wire logic                       out_ready_i,
  output      c2es_pkg::out_t             out_data_o,
  input  wire logic                       cfg_valid_i,
  output      logic                       cfg_ready_o,
  input  wire logic [c2es_pkg::YearW-1:0] cfg_data_i
);

  logic [c2es_pkg::YearW-1:0] min_year_q;
  logic                       take;
  logic                       s1_valid;
  c2es_pkg::stage_t           s1_data;

  // configuration register
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_year_q <= MinYearInit;
    end else if (cfg_valid_i && cfg_ready_o) begin
      min_year_q <= cfg_data_i;
    end
  end

  c2es_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .min_year_i (min_year_q),
    .take_i     (take),
    .s1_valid_o (s1_valid),
    .s1_data_o  (s1_data)
  );

  c2es_calc u_calc (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s1_valid_i  (s1_valid),
    .s1_data_i   (s1_data),
    .take_o      (take),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire
